[rtl/lot_pkg.sv]
// Shared types and constants for the label overlap table.
`timescale 1ns / 1ps

package lot_pkg;

  // Widest label index the table supports (LABEL_COUNT up to 1024)
  localparam int LblW = 10;

  // Record field widths on the result port
  localparam int RecLblW = 6;
  localparam int RecCntW = 21;

  // Depth of the command queue between front and back
  localparam int QDepth = 2;

  // Classified command handed from front to back
  typedef struct packed {
    logic            fetch;  // 1 = fetch next record, 0 = add a label pair
    logic            va;     // first label is inside the table
    logic            vb;     // second label is inside the table
    logic            ovl;    // both labels positive: count overlap
    logic [LblW-1:0] la;
    logic [LblW-1:0] lb;
  } lot_cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,     // clearing pass after reset
    ST_IDLE,
    ST_ADD,       // write back incremented counts
    ST_SCAN,      // walk the pair table one entry per cycle
    ST_EMIT,      // load the record into the output registers
    ST_AREA_CLR   // wipe both area tables after end of list
  } lot_state_t;

endpackage

[rtl/lot_front.sv]
// Front end: takes commands, checks label ranges and builds queue entries.
`timescale 1ns / 1ps

module lot_front #(
  parameter int LABEL_COUNT = 64
) (
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic signed [6:0] in_label_first,
  input  logic signed [6:0] in_label_second,
  input  logic              q_full,
  input  logic              clearing,
  output logic              push,
  output lot_pkg::lot_cmd_t push_cmd
);

  logic va;
  logic vb;

  // Hold off while the queue is full or the tables are being cleared
  assign busy = q_full | clearing;
  assign push = start & ~busy;

  // A label is counted only if it is non-negative and inside the table
  assign va = ~in_label_first[6] & (32'(in_label_first[5:0]) < LABEL_COUNT);
  assign vb = ~in_label_second[6] & (32'(in_label_second[5:0]) < LABEL_COUNT);

  always_comb begin
    push_cmd.fetch = in_req_type;
    push_cmd.va    = va;
    push_cmd.vb    = vb;
    // Label zero counts area but never overlap
    push_cmd.ovl   = va & vb & (in_label_first[5:0] != 6'd0) &
                     (in_label_second[5:0] != 6'd0);
    push_cmd.la    = {{(lot_pkg::LblW - 6){1'b0}}, in_label_first[5:0]};
    push_cmd.lb    = {{(lot_pkg::LblW - 6){1'b0}}, in_label_second[5:0]};
  end

endmodule

[rtl/lot_queue.sv]
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module lot_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lot_pkg::lot_cmd_t push_cmd,
  input  logic              pop,
  output lot_pkg::lot_cmd_t head,
  output logic              empty,
  output logic              full
);

  localparam int QAW = (lot_pkg::QDepth > 1) ? $clog2(lot_pkg::QDepth) : 1;
  localparam int QCW = $clog2(lot_pkg::QDepth + 1);

  lot_pkg::lot_cmd_t ent_r [lot_pkg::QDepth];
  logic [QAW-1:0]    wp_r;
  logic [QAW-1:0]    rp_r;
  logic [QCW-1:0]    cnt_r;

  assign empty = (cnt_r == QCW'(0));
  assign full  = (cnt_r == QCW'(lot_pkg::QDepth));
  assign head  = ent_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

endmodule

[rtl/lot_back.sv]
// Back end: count memories, scan cursor and the add/fetch sequencer.
`timescale 1ns / 1ps

module lot_back #(
  parameter int LABEL_COUNT = 64,
  parameter int COUNT_WIDTH = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lot_pkg::lot_cmd_t             head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          clearing,
  output logic                          out_valid,
  output logic [lot_pkg::RecLblW-1:0]   out_rec_label_first,
  output logic [lot_pkg::RecLblW-1:0]   out_rec_label_second,
  output logic [lot_pkg::RecCntW-1:0]   out_rec_area_first,
  output logic [lot_pkg::RecCntW-1:0]   out_rec_area_second,
  output logic [lot_pkg::RecCntW-1:0]   out_rec_overlap,
  output logic                          out_end_of_list
);

  localparam int LW  = $clog2(LABEL_COUNT);
  localparam int RW  = LW + 1;
  localparam int AW  = 2 * LW;
  localparam int AD  = 1 << LW;
  localparam int PD  = 1 << AW;
  localparam int CW  = COUNT_WIDTH;
  localparam int LXW = (LW > lot_pkg::RecLblW) ? LW : lot_pkg::RecLblW;
  localparam int CXW = (CW > lot_pkg::RecCntW) ? CW : lot_pkg::RecCntW;

  lot_pkg::lot_state_t state_r, state_nxt;

  // Count memories
  logic [CW-1:0] ovl_mem [PD];
  logic [CW-1:0] af_mem  [AD];
  logic [CW-1:0] as_mem  [AD];

  logic [CW-1:0] ovl_rd_r;
  logic [CW-1:0] af_rd_r;
  logic [CW-1:0] as_rd_r;

  logic          ovl_we;
  logic [AW-1:0] ovl_wa;
  logic [CW-1:0] ovl_wd;
  logic [AW-1:0] ovl_ra;
  logic          af_we;
  logic [LW-1:0] af_wa;
  logic [CW-1:0] af_wd;
  logic [LW-1:0] af_ra;
  logic          as_we;
  logic [LW-1:0] as_wa;
  logic [CW-1:0] as_wd;
  logic [LW-1:0] as_ra;

  // Cursor, scan pointer and the address whose read is in flight
  logic [RW-1:0] cur_row_r;
  logic [LW-1:0] cur_col_r;
  logic [RW-1:0] scn_row_r;
  logic [LW-1:0] scn_col_r;
  logic          pend_r;
  logic [LW-1:0] chk_row_r;
  logic [LW-1:0] chk_col_r;

  logic [AW-1:0]     clr_r;
  lot_pkg::lot_cmd_t cmd_r;
  logic [CW-1:0]     ovl_sv_r;

  logic                        out_valid_r;
  logic [lot_pkg::RecLblW-1:0] out_lbl1_r;
  logic [lot_pkg::RecLblW-1:0] out_lbl2_r;
  logic [lot_pkg::RecCntW-1:0] out_area1_r;
  logic [lot_pkg::RecCntW-1:0] out_area2_r;
  logic [lot_pkg::RecCntW-1:0] out_ovl_r;
  logic                        out_eol_r;

  logic          found;
  logic          scan_end;
  logic          chk_last;
  logic          scn_last;
  logic          add_behind;
  logic [LW-1:0] add_la;
  logic [LW-1:0] add_lb;
  logic [LXW-1:0] lbl1_x;
  logic [LXW-1:0] lbl2_x;
  logic [CXW-1:0] area1_x;
  logic [CXW-1:0] area2_x;
  logic [CXW-1:0] ovl_x;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
    return (&x) ? x : x + CW'(1);
  endfunction

  assign add_la = cmd_r.la[LW-1:0];
  assign add_lb = cmd_r.lb[LW-1:0];

  // Scan hit, end of table and row wrap detection
  assign found    = (state_r == lot_pkg::ST_SCAN) && pend_r && (ovl_rd_r != '0);
  assign scan_end = (state_r == lot_pkg::ST_SCAN) && !found &&
                    (scn_row_r == RW'(LABEL_COUNT));
  assign chk_last = (32'(chk_col_r) == LABEL_COUNT - 1);
  assign scn_last = (32'(scn_col_r) == LABEL_COUNT - 1);
  assign add_behind = ({RW'(add_la), add_lb} < {cur_row_r, cur_col_r});

  assign pop      = (state_r == lot_pkg::ST_IDLE) && !q_empty;
  assign clearing = (state_r == lot_pkg::ST_CLEAR);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lot_pkg::ST_CLEAR: begin
        if (clr_r == AW'(PD - 1)) state_nxt = lot_pkg::ST_IDLE;
      end
      lot_pkg::ST_IDLE: begin
        if (!q_empty) state_nxt = head.fetch ? lot_pkg::ST_SCAN : lot_pkg::ST_ADD;
      end
      lot_pkg::ST_ADD: begin
        state_nxt = lot_pkg::ST_IDLE;
      end
      lot_pkg::ST_SCAN: begin
        if (found) begin
          state_nxt = lot_pkg::ST_EMIT;
        end else if (scan_end) begin
          state_nxt = lot_pkg::ST_AREA_CLR;
        end
      end
      lot_pkg::ST_EMIT: begin
        state_nxt = lot_pkg::ST_IDLE;
      end
      lot_pkg::ST_AREA_CLR: begin
        if (clr_r == AW'(LABEL_COUNT - 1)) state_nxt = lot_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lot_pkg::ST_CLEAR;
      end
    endcase
  end

  // Memory port control per state
  always_comb begin
    ovl_we = 1'b0;
    ovl_wa = clr_r;
    ovl_wd = '0;
    af_we  = 1'b0;
    af_wa  = clr_r[LW-1:0];
    af_wd  = '0;
    as_we  = 1'b0;
    as_wa  = clr_r[LW-1:0];
    as_wd  = '0;
    ovl_ra = {head.la[LW-1:0], head.lb[LW-1:0]};
    af_ra  = head.la[LW-1:0];
    as_ra  = head.lb[LW-1:0];
    unique case (state_r)
      lot_pkg::ST_CLEAR: begin
        ovl_we = 1'b1;
        af_we  = (clr_r[AW-1:LW] == '0);
        as_we  = (clr_r[AW-1:LW] == '0);
      end
      lot_pkg::ST_ADD: begin
        af_we  = cmd_r.va;
        af_wa  = add_la;
        af_wd  = sat_inc(af_rd_r);
        as_we  = cmd_r.vb;
        as_wa  = add_lb;
        as_wd  = sat_inc(as_rd_r);
        ovl_we = cmd_r.ovl;
        ovl_wa = {add_la, add_lb};
        ovl_wd = sat_inc(ovl_rd_r);
      end
      lot_pkg::ST_SCAN: begin
        ovl_ra = {scn_row_r[LW-1:0], scn_col_r};
        af_ra  = chk_row_r;
        as_ra  = chk_col_r;
        // A fetched entry is cleared as it is taken
        ovl_we = found;
        ovl_wa = {chk_row_r, chk_col_r};
      end
      lot_pkg::ST_AREA_CLR: begin
        af_we = 1'b1;
        as_we = 1'b1;
      end
      lot_pkg::ST_IDLE, lot_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ovl_we) begin
      ovl_mem[ovl_wa] <= ovl_wd;
    end
    ovl_rd_r <= ovl_mem[ovl_ra];
  end

  always_ff @(posedge clk) begin
    if (af_we) begin
      af_mem[af_wa] <= af_wd;
    end
    af_rd_r <= af_mem[af_ra];
  end

  always_ff @(posedge clk) begin
    if (as_we) begin
      as_mem[as_wa] <= as_wd;
    end
    as_rd_r <= as_mem[as_ra];
  end

  // Record field widening / truncation
  assign lbl1_x  = LXW'(chk_row_r);
  assign lbl2_x  = LXW'(chk_col_r);
  assign area1_x = CXW'(af_rd_r);
  assign area2_x = CXW'(as_rd_r);
  assign ovl_x   = CXW'(ovl_sv_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lot_pkg::ST_CLEAR;
      clr_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      // Strobe for a found record or the end-of-list record
      out_valid_r <= scan_end || (state_r == lot_pkg::ST_EMIT);

      // Sweep counter for both clearing passes
      if ((state_r == lot_pkg::ST_CLEAR || state_r == lot_pkg::ST_AREA_CLR) &&
          state_nxt == state_r) begin
        clr_r <= clr_r + AW'(1);
      end else begin
        clr_r <= '0;
      end

      // Fetch starts at the cursor
      if (pop && head.fetch) begin
        pend_r <= 1'b0;
      end

      // Walk the table: issue one read, check the previous one
      if (state_r == lot_pkg::ST_SCAN && !found) begin
        pend_r <= (scn_row_r != RW'(LABEL_COUNT));
      end

      // An add behind the cursor pulls it back
      if (state_r == lot_pkg::ST_ADD && cmd_r.ovl && add_behind) begin
        cur_row_r <= RW'(add_la);
        cur_col_r <= add_lb;
      end

      if (found) begin
        if (chk_last) begin
          cur_row_r <= RW'(chk_row_r) + RW'(1);
          cur_col_r <= '0;
        end else begin
          cur_row_r <= RW'(chk_row_r);
          cur_col_r <= chk_col_r + LW'(1);
        end
      end

      if (scan_end) begin
        cur_row_r <= '0;
        cur_col_r <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head;
    end
    if (pop && head.fetch) begin
      scn_row_r <= cur_row_r;
      scn_col_r <= cur_col_r;
    end
    if (state_r == lot_pkg::ST_SCAN && !found &&
        scn_row_r != RW'(LABEL_COUNT)) begin
      chk_row_r <= scn_row_r[LW-1:0];
      chk_col_r <= scn_col_r;
      if (scn_last) begin
        scn_row_r <= scn_row_r + RW'(1);
        scn_col_r <= '0;
      end else begin
        scn_col_r <= scn_col_r + LW'(1);
      end
    end
    if (found) begin
      ovl_sv_r <= ovl_rd_r;
    end
    if (scan_end) begin
      out_lbl1_r  <= '0;
      out_lbl2_r  <= '0;
      out_area1_r <= '0;
      out_area2_r <= '0;
      out_ovl_r   <= '0;
      out_eol_r   <= 1'b1;
    end
    if (state_r == lot_pkg::ST_EMIT) begin
      out_lbl1_r  <= lbl1_x[lot_pkg::RecLblW-1:0];
      out_lbl2_r  <= lbl2_x[lot_pkg::RecLblW-1:0];
      out_area1_r <= area1_x[lot_pkg::RecCntW-1:0];
      out_area2_r <= area2_x[lot_pkg::RecCntW-1:0];
      out_ovl_r   <= ovl_x[lot_pkg::RecCntW-1:0];
      out_eol_r   <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_rec_label_first  = out_lbl1_r;
  assign out_rec_label_second = out_lbl2_r;
  assign out_rec_area_first   = out_area1_r;
  assign out_rec_area_second  = out_area2_r;
  assign out_rec_overlap      = out_ovl_r;
  assign out_end_of_list      = out_eol_r;

  // Checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_emit_record: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lot_pkg::ST_EMIT) |=> (out_valid_r && !out_eol_r))
    else $error("emitted record missing or flagged as end");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lot_pkg::ST_EMIT) |-> (ovl_sv_r != '0))
    else $error("record emitted for an empty pair");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eol_r) |-> (out_ovl_r == '0 && out_lbl1_r == '0 &&
                                    out_area1_r == '0))
    else $error("end of list record carries data");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_row_r <= RW'(LABEL_COUNT))
    else $error("scan cursor past table end");

endmodule

[rtl/label_overlap_table.sv]
// Top level of the label overlap table: front end, command queue, back end.
//
// Label pairs and fetch commands are taken when start is high and busy is
// low, and go through a two-entry command queue to a sequencer that owns the
// count memories. An add occupies the sequencer for a memory read, then a
// saturating write-back. A fetch walks the pair-table entries from the scan
// cursor to the next nonzero overlap count, one entry per cycle through the
// overlap memory's single read port; the fetch that reaches the end of the
// table returns its end-of-list record and then wipes the area tables. After
// reset the block runs a clearing pass over all count memories with busy
// high. Each record is presented for exactly one cycle with out_valid; the
// receiver cannot stall it.
`timescale 1ns / 1ps

module label_overlap_table #(
  parameter int LABEL_COUNT = 64,
  parameter int COUNT_WIDTH = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic signed [6:0]             in_label_first,
  input  logic signed [6:0]             in_label_second,
  output logic                          out_valid,
  output logic [lot_pkg::RecLblW-1:0]   out_rec_label_first,
  output logic [lot_pkg::RecLblW-1:0]   out_rec_label_second,
  output logic [lot_pkg::RecCntW-1:0]   out_rec_area_first,
  output logic [lot_pkg::RecCntW-1:0]   out_rec_area_second,
  output logic [lot_pkg::RecCntW-1:0]   out_rec_overlap,
  output logic                          out_end_of_list
);

  logic              q_full;
  logic              q_empty;
  logic              clearing;
  logic              push;
  logic              pop;
  lot_pkg::lot_cmd_t push_cmd;
  lot_pkg::lot_cmd_t head;

  // Command intake and classification
  lot_front #(
    .LABEL_COUNT (LABEL_COUNT)
  ) u_front (
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_label_first  (in_label_first),
    .in_label_second (in_label_second),
    .q_full          (q_full),
    .clearing        (clearing),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // Command queue
  lot_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Counting and scanning
  lot_back #(
    .LABEL_COUNT (LABEL_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .q_empty              (q_empty),
    .pop                  (pop),
    .clearing             (clearing),
    .out_valid            (out_valid),
    .out_rec_label_first  (out_rec_label_first),
    .out_rec_label_second (out_rec_label_second),
    .out_rec_area_first   (out_rec_area_first),
    .out_rec_area_second  (out_rec_area_second),
    .out_rec_overlap      (out_rec_overlap),
    .out_end_of_list      (out_end_of_list)
  );

endmodule
